// ===== design/irs_pkg.sv =====
// shared types, opcodes, status codes and defaults for the interrupt subscriber router
package irs_pkg;

  // fixed field widths of the request and result channels
  localparam int OP_W   = 2;
  localparam int VEC_W  = 8;
  localparam int CNT_W  = 9;
  localparam int PID_W  = 16;
  localparam int STAT_W = 2;

  // first vector that may be dispatched
  localparam int FIRST_VECTOR = 16;

  // parameter defaults
  localparam int VECTOR_COUNT_DEF = 256;
  localparam int SLOTS_DEF        = 4;
  localparam int PID_BITS_DEF     = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_DISPATCH   = 2'd0;
  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [VEC_W-1:0] vector;
    logic [CNT_W-1:0] count;
    logic [PID_W-1:0] pid;
  } irs_in_t;

  typedef struct packed {
    logic [PID_W-1:0]  target_pid;
    logic [VEC_W-1:0]  out_vector;
    logic              delivered;
    logic              vector_enabled;
    logic [STAT_W-1:0] status;
    logic              last;
  } irs_out_t;

endpackage

// ===== design/irs_ram.sv =====
// generic simple dual-port ram with registered read
module irs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/irs_seq.sv =====
// request sequencer: table walks, read-modify-write of vector words, result generation
module irs_seq
  import irs_pkg::*;
#(
  parameter int VECTOR_COUNT = VECTOR_COUNT_DEF,
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PID_BITS     = PID_BITS_DEF,
  localparam int VIDX_W      = $clog2(VECTOR_COUNT),
  localparam int WORD_W      = SLOTS * PID_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irs_in_t           in_data,
  output logic              emit_v,
  output irs_out_t          emit_d,
  input  logic              emit_rdy,
  output logic              ram_re,
  output logic [VIDX_W-1:0] ram_raddr,
  input  logic [WORD_W-1:0] ram_q,
  output logic              ram_we,
  output logic [VIDX_W-1:0] ram_waddr,
  output logic [WORD_W-1:0] ram_wdata
);

  localparam int VCNT_W = VIDX_W + 1;
  localparam int TAB_W  = SLOTS * PID_BITS;
  localparam logic [VCNT_W-1:0] VC_L   = VCNT_W'(VECTOR_COUNT);
  localparam logic [VEC_W:0]    VC_V   = (VEC_W + 1)'(VECTOR_COUNT);
  localparam logic [VEC_W+1:0]  VC_E   = (VEC_W + 2)'(VECTOR_COUNT);
  localparam logic [VEC_W:0]    FIRST_V = (VEC_W + 1)'(FIRST_VECTOR);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRD   = 5'b00100,
    S_DSEND = 5'b01000,
    S_RESP  = 5'b10000
  } irs_state_t;

  irs_state_t          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [VEC_W-1:0]    vec_r, vec_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [VCNT_W-1:0]   addr_r, addr_nxt;
  logic [VCNT_W-1:0]   lim_r, lim_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [VIDX_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic                full_r, full_nxt;
  logic                range_r, range_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic                res_en_r, res_en_nxt;
  logic [TAB_W-1:0]    slots_r, slots_nxt;
  logic                en_r, en_nxt;
  logic [SLOTS-1:0]    occ_r, occ_nxt;
  logic [VECTOR_COUNT-1:0] vld_r;

  logic [PID_BITS-1:0] pid_in_st;
  logic [PID_BITS-1:0] sel_pid;
  logic [PID_W-1:0]    tgt_pid;
  logic [WORD_W-1:0]   cur_word;
  logic [WORD_W-1:0]   reg_word;
  logic [WORD_W-1:0]   unreg_word;
  logic [SLOTS-1:0]    free_m, free_first, match_m, occ_m, occ_low, occ_clr;
  logic [VEC_W:0]      vec_ext;
  logic [VEC_W+1:0]    end_sum;
  logic                vec_ok, disp_ok, reg_range, issue;

  // stored pid width versus port pid width
  generate
    if (PID_BITS > PID_W) begin : g_pid_wide
      assign pid_in_st = {{(PID_BITS - PID_W){1'b0}}, in_data.pid};
      assign tgt_pid   = sel_pid[PID_W-1:0];
    end else if (PID_BITS == PID_W) begin : g_pid_same
      assign pid_in_st = in_data.pid;
      assign tgt_pid   = sel_pid;
    end else begin : g_pid_narrow
      assign pid_in_st = in_data.pid[PID_BITS-1:0];
      assign tgt_pid   = {{(PID_W - PID_BITS){1'b0}}, sel_pid};
    end
  endgenerate

  // range decode of the incoming request
  assign vec_ext   = {1'b0, in_data.vector};
  assign end_sum   = {2'b00, in_data.vector} + {1'b0, in_data.count};
  assign vec_ok    = vec_ext < VC_V;
  assign disp_ok   = vec_ok && (vec_ext >= FIRST_V);
  assign reg_range = (in_data.count != '0) && (end_sum > VC_E);

  // read data, entries never written read as zero
  assign cur_word = vld_r[rd_addr_r] ? ram_q : '0;

  // per-slot masks of the word just read
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      free_m[k]  = cur_word[k*PID_BITS +: PID_BITS] == '0;
      match_m[k] = cur_word[k*PID_BITS +: PID_BITS] == pid_r;
    end
  end
  assign occ_m      = ~free_m;
  assign free_first = free_m & ~(free_m - SLOTS'(1));

  // modified words for register and unregister
  always_comb begin
    reg_word   = cur_word;
    unreg_word = cur_word;
    reg_word[WORD_W-1] = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (free_first[k]) begin
        reg_word[k*PID_BITS +: PID_BITS] = pid_r;
      end
      if (match_m[k]) begin
        unreg_word[k*PID_BITS +: PID_BITS] = '0;
      end
    end
  end

  // lowest occupied slot during dispatch
  assign occ_low = occ_r & ~(occ_r - SLOTS'(1));
  assign occ_clr = occ_r & (occ_r - SLOTS'(1));
  always_comb begin
    sel_pid = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (occ_low[k]) begin
        sel_pid = sel_pid | slots_r[k*PID_BITS +: PID_BITS];
      end
    end
  end

  assign issue    = addr_r < lim_r;
  assign in_stall = state_r != S_IDLE;

  // next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    vec_nxt     = vec_r;
    pid_nxt     = pid_r;
    addr_nxt    = addr_r;
    lim_nxt     = lim_r;
    rd_pend_nxt = 1'b0;
    rd_addr_nxt = rd_addr_r;
    full_nxt    = full_r;
    range_nxt   = range_r;
    stat_nxt    = stat_r;
    res_en_nxt  = res_en_r;
    slots_nxt   = slots_r;
    en_nxt      = en_r;
    occ_nxt     = occ_r;
    ram_re      = 1'b0;
    ram_raddr   = addr_r[VIDX_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_r;
    ram_wdata   = reg_word;
    emit_v      = 1'b0;
    emit_d      = '0;
    emit_d.out_vector = vec_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          vec_nxt   = in_data.vector;
          pid_nxt   = pid_in_st;
          full_nxt  = 1'b0;
          range_nxt = 1'b0;
          case (in_data.opcode)
            OP_DISPATCH: begin
              if (disp_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = in_data.vector[VIDX_W-1:0];
                rd_addr_nxt = in_data.vector[VIDX_W-1:0];
                state_nxt   = S_DRD;
              end else begin
                stat_nxt   = STAT_RANGE;
                res_en_nxt = 1'b0;
                state_nxt  = S_RESP;
              end
            end
            OP_REGISTER: begin
              addr_nxt  = vec_ok ? {1'b0, in_data.vector[VIDX_W-1:0]} : VC_L;
              lim_nxt   = (end_sum >= VC_E) ? VC_L : end_sum[VCNT_W-1:0];
              range_nxt = reg_range;
              state_nxt = S_WALK;
            end
            OP_UNREGISTER: begin
              res_en_nxt = 1'b0;
              if (pid_in_st == '0) begin
                stat_nxt  = STAT_OK;
                state_nxt = S_RESP;
              end else begin
                addr_nxt  = '0;
                lim_nxt   = VC_L;
                state_nxt = S_WALK;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        // read one word ahead, write back the word read last cycle
        ram_re      = issue;
        rd_pend_nxt = issue;
        rd_addr_nxt = addr_r[VIDX_W-1:0];
        if (issue) begin
          addr_nxt = addr_r + VCNT_W'(1);
        end
        if (rd_pend_r) begin
          if (op_r == OP_REGISTER) begin
            ram_we    = free_m != '0;
            ram_wdata = reg_word;
            if (free_m == '0) begin
              full_nxt = 1'b1;
            end
          end else begin
            ram_we    = match_m != '0;
            ram_wdata = unreg_word;
          end
        end
        if (!issue && !rd_pend_r) begin
          res_en_nxt = 1'b0;
          stat_nxt   = range_r ? STAT_RANGE : (full_r ? STAT_FULL : STAT_OK);
          state_nxt  = S_RESP;
        end
      end
      S_DRD: begin
        slots_nxt = cur_word[TAB_W-1:0];
        en_nxt    = cur_word[WORD_W-1];
        occ_nxt   = occ_m;
        if (occ_m == '0) begin
          stat_nxt   = STAT_OK;
          res_en_nxt = cur_word[WORD_W-1];
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_DSEND;
        end
      end
      S_DSEND: begin
        // one result per occupied slot, lowest slot first
        emit_v                = 1'b1;
        emit_d.target_pid     = tgt_pid;
        emit_d.delivered      = 1'b1;
        emit_d.vector_enabled = en_r;
        emit_d.status         = STAT_OK;
        emit_d.last           = occ_clr == '0;
        if (emit_rdy) begin
          occ_nxt = occ_clr;
          if (occ_clr == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        emit_v                = 1'b1;
        emit_d.vector_enabled = res_en_r;
        emit_d.status         = stat_r;
        emit_d.last           = 1'b1;
        if (emit_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      vld_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    vec_r     <= vec_nxt;
    pid_r     <= pid_nxt;
    addr_r    <= addr_nxt;
    lim_r     <= lim_nxt;
    rd_addr_r <= rd_addr_nxt;
    full_r    <= full_nxt;
    range_r   <= range_nxt;
    stat_r    <= stat_nxt;
    res_en_r  <= res_en_nxt;
    slots_r   <= slots_nxt;
    en_r      <= en_nxt;
    occ_r     <= occ_nxt;
  end

`ifndef ASSERT_OFF
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("write and read of the same vector word in one cycle");

  a_dsend_occ: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DSEND |-> occ_r != '0)
    else $error("dispatch send with no occupied slot left");

  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == S_WALK)
    else $error("pending walk read outside of a walk");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_v && emit_rdy && emit_d.last |=> state_r == S_IDLE)
    else $error("sequencer busy after the last result of a request");

  a_disp_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_DISPATCH
      |=> state_r == S_DRD || state_r == S_RESP)
    else $error("dispatch request did not start a lookup or a response");
`endif

endmodule

// ===== design/interrupt_subscriber_router.sv =====
// top level of the interrupt subscriber router: sequencer, table ram and result register
//
//  channel | direction | payload    | handshake
//  in_     | input     | irs_in_t   | in_valid / in_stall
//  out_    | output    | irs_out_t  | out_valid / out_stall
//
//  dispatch reads the vector word and gives one result per subscriber, or one response if there is none;
//  register walks the vector words of the range inside the table, then gives one response;
//  unregister with a nonzero pid walks all VECTOR_COUNT table words, one table word per cycle through the ram ports.
//  opcode three is dropped with no result.
//  reset clears the per-vector valid bits, so the whole table reads as empty at once.
//  out_stall holds the result register; the sequencer waits only when it has a new result.
module interrupt_subscriber_router
  import irs_pkg::*;
#(
  parameter int VECTOR_COUNT = VECTOR_COUNT_DEF,
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PID_BITS     = PID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  irs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output irs_out_t out_data
);

  localparam int VIDX_W = $clog2(VECTOR_COUNT);
  localparam int WORD_W = SLOTS * PID_BITS + 1;

  logic              emit_v;
  logic              emit_rdy;
  irs_out_t          emit_d;
  logic              ram_re;
  logic              ram_we;
  logic [VIDX_W-1:0] ram_raddr;
  logic [VIDX_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] ram_wdata;
  logic              out_valid_r;
  irs_out_t          out_data_r;

  // request sequencer
  irs_seq #(
    .VECTOR_COUNT (VECTOR_COUNT),
    .SLOTS        (SLOTS),
    .PID_BITS     (PID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .emit_v    (emit_v),
    .emit_d    (emit_d),
    .emit_rdy  (emit_rdy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_q     (ram_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // subscriber table with enable bit in the top position
  irs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VECTOR_COUNT)
  ) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // result register
  assign emit_rdy = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_v && emit_rdy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_v && emit_rdy) begin
      out_data_r <= emit_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/tb_interrupt_subscriber_router.sv =====
// testbench for the interrupt subscriber router: route scoreboard, drivers and run sequence
`timescale 1ns / 1ps

module tb_interrupt_subscriber_router
  import irs_pkg::*;
();

  // table predictor and result checker
  class route_scoreboard;

    logic [PID_W-1:0] slot_pid [VECTOR_COUNT_DEF][SLOTS_DEF];
    bit               enabled  [VECTOR_COUNT_DEF];
    irs_out_t         expected_routes [$];
    int               mismatches;
    int               results_checked;
    int               deliveries;
    int               full_flags;
    int               range_flags;

    function new();
      foreach (slot_pid[v, s]) slot_pid[v][s] = '0;
      foreach (enabled[v]) enabled[v] = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      deliveries      = 0;
      full_flags      = 0;
      range_flags     = 0;
    endfunction

    // update the table copy and queue the results one request causes
    function void note_request(irs_in_t req);
      irs_out_t r;
      int       occupied;
      int       seen;
      int       v;
      bit       full;
      bit       past;
      bit       placed;
      r            = '0;
      r.out_vector = req.vector;
      r.last       = 1'b1;
      case (req.opcode)
        OP_DISPATCH: begin
          if (req.vector < FIRST_VECTOR || req.vector >= VECTOR_COUNT_DEF) begin
            r.status = STAT_RANGE;
            expected_routes.push_back(r);
          end else begin
            r.vector_enabled = enabled[req.vector];
            occupied = 0;
            for (int s = 0; s < SLOTS_DEF; s++)
              if (slot_pid[req.vector][s] != '0) occupied++;
            if (occupied == 0) begin
              expected_routes.push_back(r);
            end else begin
              // one notification per occupied slot, in slot order
              seen = 0;
              for (int s = 0; s < SLOTS_DEF; s++) begin
                if (slot_pid[req.vector][s] != '0) begin
                  seen++;
                  r.target_pid = slot_pid[req.vector][s];
                  r.delivered  = 1'b1;
                  r.last       = (seen == occupied);
                  expected_routes.push_back(r);
                end
              end
            end
          end
        end
        OP_REGISTER: begin
          full = 1'b0;
          past = 1'b0;
          for (int i = 0; i < int'(req.count); i++) begin
            v = int'(req.vector) + i;
            if (v >= VECTOR_COUNT_DEF) begin
              past = 1'b1;
            end else begin
              // first empty slot takes the pid, enable is set even for pid zero
              placed = 1'b0;
              for (int s = 0; s < SLOTS_DEF && !placed; s++) begin
                if (slot_pid[v][s] == '0) begin
                  slot_pid[v][s] = req.pid;
                  enabled[v]     = 1'b1;
                  placed         = 1'b1;
                end
              end
              if (!placed) full = 1'b1;
            end
          end
          r.status = past ? STAT_RANGE : (full ? STAT_FULL : STAT_OK);
          expected_routes.push_back(r);
        end
        OP_UNREGISTER: begin
          if (req.pid != '0)
            foreach (slot_pid[vv, s])
              if (slot_pid[vv][s] == req.pid) slot_pid[vv][s] = '0;
          expected_routes.push_back(r);
        end
        default: begin
          // dropped opcode, no result
        end
      endcase
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(irs_out_t got);
      irs_out_t want;
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_routes.pop_front();
      results_checked++;
      if (got.delivered) deliveries++;
      if (got.status == STAT_FULL) full_flags++;
      if (got.status == STAT_RANGE) range_flags++;
      compare_field("target_pid", want.target_pid, got.target_pid);
      compare_field("out_vector", want.out_vector, got.out_vector);
      compare_field("delivered", want.delivered, got.delivered);
      compare_field("vector_enabled", want.vector_enabled, got.vector_enabled);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  localparam logic [OP_W-1:0] OP_DROPPED = 2'd3;
  localparam int RANDOM_ITEMS   = 100;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  irs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  irs_out_t out_data;

  route_scoreboard routes = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_requested = 1'b0;
  int idle_cycles   = 0;
  int n_dispatch    = 0;
  int n_register    = 0;
  int n_unregister  = 0;
  int n_dropped     = 0;
  int stalled_offers = 0;

  interrupt_subscriber_router dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      routes.note_request(in_data);
      case (in_data.opcode)
        OP_DISPATCH:   n_dispatch++;
        OP_REGISTER:   n_register++;
        OP_UNREGISTER: n_unregister++;
        default:       n_dropped++;
      endcase
    end
    if (rst_n && in_valid && in_stall) stalled_offers++;
    if (rst_n && out_valid && !out_stall) routes.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog on cycles with no handshake
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result side stall, with one long hold-off on demand
  initial begin
    forever begin
      @(negedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one request, entered and left at a falling edge
  task automatic send_request(input irs_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (routes.expected_routes.size() != 0) @(negedge clk);
  endtask

  function automatic irs_in_t make_request(logic [OP_W-1:0] op, int vec, int cnt, int pid);
    irs_in_t req;
    req.opcode = op;
    req.vector = VEC_W'(vec);
    req.count  = CNT_W'(cnt);
    req.pid    = PID_W'(pid);
    return req;
  endfunction

  // mostly a small window of vectors and pids so the table fills and empties
  function automatic irs_in_t random_request();
    irs_in_t req;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) req.opcode = OP_DISPATCH;
    else if (pick < 80) req.opcode = OP_REGISTER;
    else if (pick < 93) req.opcode = OP_UNREGISTER;
    else req.opcode = OP_DROPPED;
    if ($urandom_range(0, 7) == 0) req.vector = VEC_W'($urandom_range(0, 255));
    else req.vector = VEC_W'($urandom_range(FIRST_VECTOR, FIRST_VECTOR + 15));
    if (req.opcode == OP_REGISTER && $urandom_range(0, 11) != 0)
      req.count = CNT_W'($urandom_range(0, 4));
    else
      req.count = CNT_W'($urandom_range(0, 256));
    if ($urandom_range(0, 9) == 0) req.pid = PID_W'($urandom_range(0, 65535));
    else req.pid = PID_W'($urandom_range(0, 6));
    return req;
  endfunction

  task automatic random_phase(input int items);
    irs_in_t req;
    int      counted;
    counted = 0;
    while (counted < items) begin
      req = random_request();
      send_request(req);
      if (req.opcode != OP_DROPPED) counted++;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: range edges, empty and full vectors, pid zero, wide ranges
    send_request(make_request(OP_DISPATCH, 0, 0, 0));
    send_request(make_request(OP_DISPATCH, FIRST_VECTOR - 1, 0, 0));
    send_request(make_request(OP_DISPATCH, FIRST_VECTOR, 0, 0));
    send_request(make_request(OP_DISPATCH, 255, 0, 0));
    send_request(make_request(OP_REGISTER, 16, 1, 16'hFFFF));
    send_request(make_request(OP_DISPATCH, 16, 0, 0));
    send_request(make_request(OP_REGISTER, 40, 0, 7));
    send_request(make_request(OP_REGISTER, 20, 1, 0));
    send_request(make_request(OP_DISPATCH, 20, 0, 0));
    send_request(make_request(OP_REGISTER, 0, 256, 1));
    send_request(make_request(OP_REGISTER, 16, 1, 2));
    send_request(make_request(OP_REGISTER, 16, 1, 3));
    send_request(make_request(OP_REGISTER, 16, 1, 4));
    send_request(make_request(OP_DISPATCH, 16, 0, 0));
    send_request(make_request(OP_REGISTER, 250, 10, 5));
    send_request(make_request(OP_REGISTER, 16, 241, 6));
    send_request(make_request(OP_REGISTER, 252, 4, 6));
    send_request(make_request(OP_UNREGISTER, 8'h5A, 0, 0));
    send_request(make_request(OP_UNREGISTER, 8'hA5, 256, 1));
    send_request(make_request(OP_DISPATCH, 16, 0, 0));
    send_request(make_request(OP_DISPATCH, 255, 0, 0));
    send_request(make_request(OP_REGISTER, 16, 1, 9));
    send_request(make_request(OP_DISPATCH, 16, 0, 0));
    send_request(make_request(OP_DROPPED, 16, 1, 1));
    send_request(make_request(OP_UNREGISTER, 0, 0, 6));
    send_request(make_request(OP_DISPATCH, 20, 0, 0));
    drain_results();

    // sender rarely idles, receiver mostly stalls
    send_idle_pct = 12;
    stall_pct     = 65;
    random_phase(RANDOM_ITEMS / 3);
    drain_results();

    // sender mostly idles, receiver rarely stalls
    send_idle_pct = 65;
    stall_pct     = 12;
    random_phase(RANDOM_ITEMS / 3);
    drain_results();

    // no idling, opened by a long result hold-off under a dispatch burst
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_requested = 1'b1;
    for (int i = 0; i < 16; i++)
      send_request(make_request(OP_DISPATCH, FIRST_VECTOR + (i % 4), 0, 0));
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("requests: %0d dispatch, %0d register, %0d unregister, %0d dropped",
             n_dispatch, n_register, n_unregister, n_dropped);
    $display("results: %0d checked, %0d deliveries, %0d full flags, %0d range flags, %0d stalls",
             routes.results_checked, routes.deliveries, routes.full_flags, routes.range_flags,
             stalled_offers);
    if (routes.mismatches == 0 && routes.expected_routes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
